FILE: rtl/core/tfeb_pkg.sv
// ---------------------------------------------------------------------------
// Time frame event builder package
// Shared types and constants for the event builder core.
// ---------------------------------------------------------------------------
`default_nettype none
package tfeb_pkg;

  localparam int unsigned IdW = 32;
  localparam int unsigned LenW = 40;
  localparam int unsigned CntW = 5;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgAddrW-1:0] RegNeeded = 2'd0;
  localparam logic [CfgAddrW-1:0] RegTimeout = 2'd1;
  localparam logic [CfgAddrW-1:0] RegHeader = 2'd2;

  localparam logic KindFrag = 1'b0;
  localparam logic KindTick = 1'b1;

  localparam logic [1:0] EvComplete = 2'd0;
  localparam logic [1:0] EvDiscard = 2'd1;
  localparam logic [1:0] EvLate = 2'd2;
  localparam logic [1:0] EvOverflow = 2'd3;

  localparam logic [LenW-1:0] LenMax = {LenW{1'b1}};

  typedef struct packed {
    logic kind;
    logic [IdW-1:0] frame_id;
    logic [31:0] fragment_bytes;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic [IdW-1:0] result_id;
    logic [CntW-1:0] sources_seen;
    logic [LenW-1:0] total_length;
    logic last;
  } out_item_t;

  function automatic logic [LenW-1:0] sat_add(input logic [LenW-1:0] a,
                                             input logic [LenW-1:0] b);
    logic [LenW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LenW] ? LenMax : s[LenW-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/tfeb_front.sv
// ---------------------------------------------------------------------------
// Event builder front end
// Accepts items into a two-entry queue toward the slot engine.
// ---------------------------------------------------------------------------
`default_nettype none
module tfeb_front
  import tfeb_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  in_item_t      item_i,
  input  wire logic     pop_i,
  output logic          full_o,
  output logic          avail_o,
  output in_item_t      head_o
);

  in_item_t buf_q [2];
  in_item_t buf_d [2];
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    if (pop_i && cnt_q != 2'd0) begin
      buf_d[0] = buf_q[1];
      cnt_d = cnt_d - 2'd1;
    end
    if (push_i) begin
      buf_d[cnt_d[0]] = item_i;
      cnt_d = cnt_d + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  assign full_o = (cnt_q == 2'd2);
  assign avail_o = (cnt_q != 2'd0);
  assign head_o = buf_q[0];

endmodule
`default_nettype wire

FILE: rtl/core/tfeb_back.sv
// ---------------------------------------------------------------------------
// Event builder slot engine
// Matches fragments against the slot table and scans slots on ticks.
// ---------------------------------------------------------------------------
`default_nettype none
module tfeb_back
  import tfeb_pkg::*;
#(
  parameter int unsigned SLOTS = 16,
  parameter int unsigned DISCARD_DEPTH = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          avail_i,
  input  in_item_t           item_i,
  output logic               pop_o,
  input  wire logic [CntW-1:0] need_i,
  input  wire logic [31:0]   timeout_i,
  input  wire logic [7:0]    header_i,
  output logic               res_valid_o,
  output out_item_t          res_o
);

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned DW = (DISCARD_DEPTH > 1) ? $clog2(DISCARD_DEPTH) : 1;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StLook = 5'b00010,
    StFrag = 5'b00100,
    StScan = 5'b01000,
    StDone = 5'b10000
  } state_e;

  state_e state_q, state_d;
  in_item_t cur_q;
  logic [31:0] now_q;
  logic [SLOTS-1:0] sv_q;
  logic [IdW-1:0] sf_q [SLOTS];
  logic [CntW-1:0] sc_q [SLOTS];
  logic [LenW-1:0] sl_q [SLOTS];
  logic [31:0] ss_q [SLOTS];
  logic [DISCARD_DEPTH-1:0] dv_q;
  logic [IdW-1:0] di_q [DISCARD_DEPTH];
  logic [DW-1:0] dp_q;
  logic [SW-1:0] idx_q;
  logic hit_q, free_q, late_q;
  logic [SW-1:0] hidx_q, fidx_q;
  logic [SLOTS-1:0] pend_q;

  // Match lines, registered in the look stage.
  logic [SLOTS-1:0] match_v, free_v;
  logic late_v;
  always_comb begin
    late_v = 1'b0;
    for (int i = 0; i < DISCARD_DEPTH; i++)
      if (dv_q[i] && di_q[i] == cur_q.frame_id) late_v = 1'b1;
    for (int i = 0; i < SLOTS; i++) begin
      match_v[i] = sv_q[i] && sf_q[i] == cur_q.frame_id;
      free_v[i] = !sv_q[i];
    end
  end

  logic m_any, f_any;
  logic [SW-1:0] m_idx, f_idx;
  always_comb begin
    m_any = 1'b0; f_any = 1'b0; m_idx = '0; f_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (match_v[i]) begin m_any = 1'b1; m_idx = SW'(i); end
      if (free_v[i]) begin f_any = 1'b1; f_idx = SW'(i); end
    end
  end

  // Remaining work after the scanned slot, so the last result is known.
  logic [SLOTS-1:0] rest_mask;
  always_comb begin
    for (int i = 0; i < SLOTS; i++) rest_mask[i] = (SW'(i) > idx_q);
  end

  logic [SW-1:0] fs;
  logic [CntW-1:0] cnt_new;
  logic [LenW-1:0] len_new;
  logic [31:0] age;
  logic s_comp, s_disc;
  always_comb begin
    fs = hit_q ? hidx_q : fidx_q;
    cnt_new = hit_q ? ((sc_q[fs] < CntW'(16)) ? sc_q[fs] + CntW'(1) : sc_q[fs])
                    : CntW'(1);
    len_new = hit_q ? sat_add(sl_q[fs], LenW'(cur_q.fragment_bytes))
                    : LenW'(cur_q.fragment_bytes);
    age = now_q - ss_q[idx_q];
    s_comp = sv_q[idx_q] && sc_q[idx_q] >= need_i;
    s_disc = sv_q[idx_q] && !s_comp && age > timeout_i;
  end

  // Due slots are judged against the tick count that the scan will see.
  logic [SLOTS-1:0] due_v;
  always_comb begin
    for (int i = 0; i < SLOTS; i++)
      due_v[i] = sv_q[i] &&
                 (sc_q[i] >= need_i || (now_q + 32'd1 - ss_q[i]) > timeout_i);
  end

  always_comb begin
    state_d = state_q;
    pop_o = 1'b0;
    case (state_q)
      StIdle: if (avail_i) begin
        pop_o = 1'b1;
        state_d = StLook;
      end
      StLook: state_d = (cur_q.kind == KindTick) ? StScan : StFrag;
      StFrag: state_d = StDone;
      StScan: if (idx_q == SW'(SLOTS - 1)) state_d = StDone;
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      now_q <= '0;
      sv_q <= '0;
      dv_q <= '0;
      dp_q <= '0;
      res_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      res_valid_o <= 1'b0;
      if (state_q == StLook && cur_q.kind == KindTick) now_q <= now_q + 32'd1;
      if (state_q == StFrag && !late_q && (hit_q || free_q)) begin
        sv_q[fs] <= !(cnt_new >= need_i);
        res_valid_o <= cnt_new >= need_i;
      end
      if (state_q == StFrag && (late_q || !(hit_q || free_q))) res_valid_o <= 1'b1;
      if (state_q == StScan && (s_comp || s_disc)) begin
        sv_q[idx_q] <= 1'b0;
        res_valid_o <= 1'b1;
        if (s_disc) begin
          dv_q[dp_q] <= 1'b1;
          dp_q <= (dp_q == DW'(DISCARD_DEPTH - 1)) ? '0 : dp_q + DW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= item_i;
    if (state_q == StLook) begin
      hit_q <= m_any; free_q <= f_any; late_q <= late_v;
      hidx_q <= m_idx; fidx_q <= f_idx;
      pend_q <= due_v;
      idx_q <= '0;
    end
    if (state_q == StScan) idx_q <= idx_q + SW'(1);
    if (state_q == StFrag && !late_q && (hit_q || free_q)) begin
      sc_q[fs] <= cnt_new;
      sl_q[fs] <= len_new;
      if (!hit_q) begin
        sf_q[fs] <= cur_q.frame_id;
        ss_q[fs] <= now_q;
      end
    end
    if (state_q == StScan && s_disc) di_q[dp_q] <= sf_q[idx_q];
    res_o.last <= 1'b1;
    if (state_q == StFrag) begin
      res_o.result_id <= cur_q.frame_id;
      res_o.sources_seen <= '0;
      res_o.total_length <= '0;
      if (late_q) res_o.event_res <= EvLate;
      else if (!(hit_q || free_q)) res_o.event_res <= EvOverflow;
      else begin
        res_o.event_res <= EvComplete;
        res_o.sources_seen <= cnt_new;
        res_o.total_length <= sat_add(len_new, LenW'(header_i));
      end
    end
    if (state_q == StScan) begin
      res_o.result_id <= sf_q[idx_q];
      res_o.sources_seen <= sc_q[idx_q];
      res_o.event_res <= s_comp ? EvComplete : EvDiscard;
      res_o.total_length <= s_comp ? sat_add(sl_q[idx_q], LenW'(header_i)) : '0;
      res_o.last <= (pend_q & rest_mask) == '0;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/time_frame_event_builder_core.sv
// ---------------------------------------------------------------------------
// Time frame event builder core
// Gathers frame fragments into pending slots and reports completions,
// timeouts, late fragments and table overflows.
// ---------------------------------------------------------------------------
// An item is taken when start is high and busy is low; a two-entry queue
// takes items while the slot engine works. A fragment passes through the
// engine in fetch, match, update and report steps and gives at most one
// result. On a tick the engine visits one slot per cycle and gives one
// result per completed or timed-out slot. Each result appears on result_o
// for one cycle with result_valid_o high and cannot be held off by the
// receiver. Configuration writes are registered before they apply.
`default_nettype none
module time_frame_event_builder_core
  import tfeb_pkg::*;
#(
  parameter int unsigned SLOTS = 16,
  parameter int unsigned DISCARD_DEPTH = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  in_item_t                 item_i,
  output logic                     result_valid_o,
  output out_item_t                result_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  logic [CntW-1:0] need_raw_q;
  logic [31:0] timeout_q;
  logic [7:0] header_q;
  logic [CntW-1:0] need_eff;

  // Needed count is clamped into one to sixteen.
  assign need_eff = (need_raw_q == '0) ? CntW'(1) :
                    (need_raw_q > CntW'(16)) ? CntW'(16) : need_raw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      need_raw_q <= CntW'(1);
      timeout_q <= 32'd1000;
      header_q <= 8'd16;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        RegNeeded: need_raw_q <= cfg_data_i[CntW-1:0];
        RegTimeout: timeout_q <= cfg_data_i;
        RegHeader: header_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  logic q_full, q_avail, q_pop;
  in_item_t q_head;

  assign busy = q_full;

  tfeb_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (start && !q_full),
    .item_i  (item_i),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .avail_o (q_avail),
    .head_o  (q_head)
  );

  tfeb_back #(
    .SLOTS         (SLOTS),
    .DISCARD_DEPTH (DISCARD_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (q_avail),
    .item_i      (q_head),
    .pop_o       (q_pop),
    .need_i      (need_eff),
    .timeout_i   (timeout_q),
    .header_i    (header_q),
    .res_valid_o (result_valid_o),
    .res_o       (result_o)
  );

endmodule
`default_nettype wire
